@@ rtl/core/xfr_pkg.sv @@
`default_nettype none

package xfr_pkg;

    // Frame bytes and commands
    localparam logic [7:0] HDR_FIRST  = 8'hA5;
    localparam logic [7:0] HDR_SECOND = 8'h5A;
    localparam logic [7:0] CMD_TRACK   = 8'h01;
    localparam logic [7:0] CMD_MISSING = 8'h04;
    localparam logic [7:0] CMD_HALT    = 8'hFF;

    // Body byte positions within a frame
    localparam logic [3:0] POS_CMD      = 4'd2;
    localparam logic [3:0] POS_PAN_LO   = 4'd3;
    localparam logic [3:0] POS_PAN_HI   = 4'd4;
    localparam logic [3:0] POS_TILT_LO  = 4'd5;
    localparam logic [3:0] POS_TILT_HI  = 4'd6;
    localparam logic [3:0] POS_CHECK    = 4'd9;

    // Timing
    localparam int          WIN_W      = 10;
    localparam logic [WIN_W-1:0] WINDOW_MS = WIN_W'(500);
    localparam logic [15:0] CENTER_POS = 16'd900;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration
    localparam int          CFG_IDX_W       = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP    = CFG_IDX_W'(1);
    localparam logic [15:0] LOST_TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  TICK_STEP_RST    = 8'd10;

    // Result event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_TARGET = 2'd1;
    localparam logic [1:0] EV_LOST   = 2'd2;
    localparam logic [1:0] EV_STOP   = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_TARGET,
        OP_LOST,
        OP_STOP
    } op_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  frame_event;
        logic [15:0] target_pan;
        logic [15:0] target_tilt;
        logic        target_lost;
        logic [7:0]  frame_rate;
    } out_item_t;

    // One classified item on its way from the parser to the executor
    typedef struct packed {
        op_t         op;
        logic [15:0] pan;
        logic [15:0] tilt;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/xfr_front.sv @@
`default_nettype none

module xfr_front
    import xfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire in_item_t  item,
    output q_entry_t       entry
);

    typedef enum logic [1:0] {
        PH_HDR1,
        PH_HDR2,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  chk_reg, chk_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] pan_reg, pan_next;
    logic [15:0] tilt_reg, tilt_next;
    op_t         op;
    logic [7:0]  b;

    assign b = item.rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        chk_next   = chk_reg;
        cmd_next   = cmd_reg;
        pan_next   = pan_reg;
        tilt_next  = tilt_reg;
        op         = OP_NONE;
        if (item.kind == KIND_TICK)
        begin
            op = OP_TICK;
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if (b == HDR_FIRST)
                    begin
                        chk_next   = b;
                        phase_next = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    if (b == HDR_SECOND)
                    begin
                        chk_next   = HDR_FIRST ^ b;
                        pos_next   = POS_CMD;
                        phase_next = PH_BODY;
                    end
                    else if (b == HDR_FIRST)
                    begin
                        chk_next = b;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_BODY:
                begin
                    case (pos_reg)
                        POS_CMD:     cmd_next  = b;
                        POS_PAN_LO:  pan_next  = {8'h00, b};
                        POS_PAN_HI:  pan_next  = {b, pan_reg[7:0]};
                        POS_TILT_LO: tilt_next = {8'h00, b};
                        POS_TILT_HI: tilt_next = {b, tilt_reg[7:0]};
                        default:     ;
                    endcase
                    if (pos_reg >= POS_CHECK)
                    begin
                        phase_next = PH_HDR1;
                        pos_next   = 4'd0;
                        if (b == chk_reg)
                        begin
                            unique case (cmd_reg)
                                CMD_TRACK:   op = OP_TARGET;
                                CMD_MISSING: op = OP_LOST;
                                CMD_HALT:    op = OP_STOP;
                                default:     op = OP_NONE;
                            endcase
                        end
                    end
                    else
                    begin
                        chk_next = chk_reg ^ b;
                        pos_next = pos_reg + 4'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    // Pan and tilt are complete by the check byte
    assign entry = '{op: op, pan: pan_reg, tilt: tilt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
            pos_reg   <= 4'd0;
            chk_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            pan_reg   <= 16'd0;
            tilt_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            chk_reg   <= chk_next;
            cmd_reg   <= cmd_next;
            pan_reg   <= pan_next;
            tilt_reg  <= tilt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/xfr_queue.sv @@
`default_nettype none

module xfr_queue
    import xfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire q_entry_t  push_entry,
    input  wire logic      pop,
    output q_entry_t       pop_entry,
    output q_status_t      status
);

    q_entry_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/xfr_back.sv @@
`default_nettype none

module xfr_back
    import xfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire q_status_t            q_stat,
    input  wire q_entry_t             entry,
    output logic                      pop,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data
);

    logic [15:0]      timeout_reg;
    logic [7:0]       step_reg;
    logic [15:0]      pan_reg, pan_next;
    logic [15:0]      tilt_reg, tilt_next;
    logic             lost_reg, lost_next;
    logic [31:0]      since_frame_reg, since_frame_next;
    logic [WIN_W-1:0] since_win_reg, since_win_next, win_sum;
    logic [7:0]       frames_reg, frames_next;
    logic [7:0]       rate_reg, rate_next;
    logic [1:0]       event_code;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    assign pop       = !q_stat.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign win_sum   = since_win_reg + WIN_W'(step_reg);

    always_comb
    begin
        pan_next         = pan_reg;
        tilt_next        = tilt_reg;
        lost_next        = lost_reg;
        since_frame_next = since_frame_reg;
        since_win_next   = since_win_reg;
        frames_next      = frames_reg;
        rate_next        = rate_reg;
        event_code       = EV_NONE;
        case (entry.op)
            OP_TICK:
            begin
                since_frame_next = since_frame_reg + 32'(step_reg);
                since_win_next   = win_sum;
                if (win_sum >= WINDOW_MS)
                begin
                    rate_next      = {frames_reg[6:0], 1'b0};
                    frames_next    = 8'd0;
                    since_win_next = '0;
                end
            end
            OP_TARGET:
            begin
                pan_next         = entry.pan;
                tilt_next        = entry.tilt;
                lost_next        = 1'b0;
                since_frame_next = 32'd0;
                frames_next      = frames_reg + 8'd1;
                event_code       = EV_TARGET;
            end
            OP_LOST:
            begin
                lost_next        = 1'b1;
                since_frame_next = 32'd0;
                event_code       = EV_LOST;
            end
            OP_STOP:
            begin
                lost_next  = 1'b1;
                event_code = EV_STOP;
            end
            default: ;
        endcase
        // Latch lost once the frame gap runs past the timeout
        if (since_frame_next > 32'(timeout_reg))
            lost_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= LOST_TIMEOUT_RST;
            step_reg    <= TICK_STEP_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_LOST_TIMEOUT)
                timeout_reg <= cfg_data;
            else if (cfg_index == CFG_TICK_STEP)
                step_reg <= cfg_data[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_reg         <= CENTER_POS;
            tilt_reg        <= CENTER_POS;
            lost_reg        <= 1'b1;
            since_frame_reg <= 32'd0;
            since_win_reg   <= '0;
            frames_reg      <= 8'd0;
            rate_reg        <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pan_reg         <= pan_next;
                tilt_reg        <= tilt_next;
                lost_reg        <= lost_next;
                since_frame_reg <= since_frame_next;
                since_win_reg   <= since_win_next;
                frames_reg      <= frames_next;
                rate_reg        <= rate_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= '{frame_event: event_code, target_pan: pan_next,
                              target_tilt: tilt_next, target_lost: lost_next,
                              frame_rate: rate_next};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/xor_checked_target_frame_receiver_core.sv @@
// Path: an accepted transaction is written into the queue, and the executor
// pops it into the output register once that register is free or being taken.
// Throughput: one transaction per cycle while the queue has room and the
// output is not stalled; parser and executor update state once per item.
// Reset (rst_n, async, active low): parser waits for a header, targets at
// center, target flagged lost, timeout 500 ms, tick step 10 ms, queue empty.
`default_nettype none

module xor_checked_target_frame_receiver_core
    import xfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    // Front end: the frame parser classifies each input transaction into
    // one operation (tick, target, lost, stop or nothing) and pushes it.
    // Back end: the executor pops one operation per cycle unless stalled; it
    // updates the targets, window counters, lost flag and output register.
    // A two-entry queue sits between them so either side can stall alone.

    q_entry_t  front_entry;
    q_entry_t  q_head;
    q_status_t q_stat;
    logic      in_accept;
    logic      q_pop;

    // Accept while the queue has room; registers always take writes
    assign in_ready  = !q_stat.full;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    xfr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_data),
        .entry  (front_entry)
    );

    xfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_entry (front_entry),
        .pop        (q_pop),
        .pop_entry  (q_head),
        .status     (q_stat)
    );

    xfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .entry     (q_head),
        .pop       (q_pop),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // Never push into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !q_stat.full)
        else $error("push into full queue");

    // Never pop an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // A target frame always clears the lost flag
    a_target_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.frame_event == EV_TARGET) |-> !out_data.target_lost)
        else $error("target frame left lost flag set");

    // Lost and stop frames always set the lost flag
    a_lost_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.frame_event == EV_LOST ||
                       out_data.frame_event == EV_STOP)) |-> out_data.target_lost)
        else $error("lost or stop frame without lost flag");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
module tb;
    import xfr_pkg::*;

    // Local view of the frame parser, kept alongside the block
    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        IN_BODY,
        PHASE_SPARE
    } parse_phase_t;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 10;

    // Command outside the decoded set, and register indexes with no register
    localparam logic [7:0] CMD_IGNORED = 8'h80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Stimulus and scoreboard
    in_item_t serial_items[$];
    out_item_t target_reports[$];
    int items_sent = 0;
    int items_taken = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    bit in_taken = 1'b0;
    bit cfg_taken = 1'b0;
    out_item_t want;

    // Idle control; written by the sequence only right after a rising edge
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;

    // Predicted receiver state, reset values
    parse_phase_t frm_phase = HUNT_FIRST;
    logic [3:0] frm_pos = '0;
    logic [7:0] frm_xor = '0;
    logic [7:0] cmd_hold = '0;
    logic [15:0] pan_hold = '0;
    logic [15:0] tilt_hold = '0;
    logic [15:0] pan_now = CENTER_POS;
    logic [15:0] tilt_now = CENTER_POS;
    logic lost_now = 1'b1;
    logic [31:0] ms_now = '0;
    logic [31:0] ms_last_frame = '0;
    logic [7:0] win_count = '0;
    logic [31:0] ms_win_start = '0;
    logic [7:0] rate_now = '0;
    logic [15:0] lost_ms = LOST_TIMEOUT_RST;
    logic [7:0] step_ms = TICK_STEP_RST;

    xor_checked_target_frame_receiver_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Advance the predicted receiver by one item and return the report it owes
    function automatic out_item_t track_target(in_item_t it);
        logic [1:0] ev;
        logic [7:0] b;
        out_item_t r;
        ev = EV_NONE;
        b = it.rx_byte;
        if (it.kind == KIND_TICK)
        begin
            // Advance time; close the rate window once 500 ms have gone by
            ms_now = ms_now + 32'(step_ms);
            if ((ms_now - ms_win_start) >= 32'(WINDOW_MS))
            begin
                rate_now = {win_count[6:0], 1'b0};
                win_count = '0;
                ms_win_start = ms_now;
            end
        end
        else
        begin
            case (frm_phase)
                HUNT_FIRST:
                begin
                    if (b == HDR_FIRST)
                    begin
                        frm_xor = b;
                        frm_phase = HUNT_SECOND;
                    end
                end
                HUNT_SECOND:
                begin
                    // A repeated first header restarts the frame in place
                    if (b == HDR_SECOND)
                    begin
                        frm_xor = HDR_FIRST ^ b;
                        frm_pos = POS_CMD;
                        frm_phase = IN_BODY;
                    end
                    else if (b == HDR_FIRST)
                    begin
                        frm_xor = b;
                    end
                    else
                    begin
                        frm_phase = HUNT_FIRST;
                    end
                end
                IN_BODY:
                begin
                    case (frm_pos)
                        POS_CMD:     cmd_hold = b;
                        POS_PAN_LO:  pan_hold = {8'h00, b};
                        POS_PAN_HI:  pan_hold[15:8] = b;
                        POS_TILT_LO: tilt_hold = {8'h00, b};
                        POS_TILT_HI: tilt_hold[15:8] = b;
                        default: ;
                    endcase
                    if (frm_pos >= POS_CHECK)
                    begin
                        frm_phase = HUNT_FIRST;
                        frm_pos = '0;
                        // Drop the frame silently when the check byte disagrees
                        if (b == frm_xor)
                        begin
                            if (cmd_hold == CMD_TRACK)
                            begin
                                pan_now = pan_hold;
                                tilt_now = tilt_hold;
                                lost_now = 1'b0;
                                ms_last_frame = ms_now;
                                win_count = win_count + 8'd1;
                                ev = EV_TARGET;
                            end
                            else if (cmd_hold == CMD_MISSING)
                            begin
                                lost_now = 1'b1;
                                ms_last_frame = ms_now;
                                ev = EV_LOST;
                            end
                            else if (cmd_hold == CMD_HALT)
                            begin
                                lost_now = 1'b1;
                                ev = EV_STOP;
                            end
                        end
                    end
                    else
                    begin
                        frm_xor = frm_xor ^ b;
                        frm_pos = frm_pos + 4'd1;
                    end
                end
                default: frm_phase = HUNT_FIRST;
            endcase
        end
        // Latch the lost flag once the frame stamp is too old
        if ((ms_now - ms_last_frame) > 32'(lost_ms))
            lost_now = 1'b1;
        r.frame_event = ev;
        r.target_pan = pan_now;
        r.target_tilt = tilt_now;
        r.target_lost = lost_now;
        r.frame_rate = rate_now;
        return r;
    endfunction

    // Driver: offer the next queued item at the falling edge; hold it until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (serial_items.size() != 0)
            begin
                in_data <= serial_items.pop_front();
                in_valid <= 1'b1;
                // Occasionally follow this item with an idle burst
                if (idle_on && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 14);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in random bursts, plus one long hold on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: sample every handshake at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
            else
            begin
                // Apply a register write to the predicted configuration
                if (cfg_valid && cfg_ready)
                begin
                    if (cfg_index == CFG_LOST_TIMEOUT)
                        lost_ms = cfg_data;
                    else if (cfg_index == CFG_TICK_STEP)
                        step_ms = cfg_data[7:0];
                    cfg_taken = 1'b1;
                end
                // Predict the report for each input transaction
                if (in_valid && in_ready)
                begin
                    target_reports.push_back(track_target(in_data));
                    items_taken++;
                    in_taken = 1'b1;
                end
                // Check each output transaction against the oldest prediction
                if (out_valid && out_ready)
                begin
                    if (target_reports.size() == 0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: unexpected ev=%0d pan=%0d tilt=%0d lost=%0d rate=%0d",
                                     $time, out_data.frame_event, out_data.target_pan,
                                     out_data.target_tilt, out_data.target_lost,
                                     out_data.frame_rate);
                    end
                    else
                    begin
                        want = target_reports.pop_front();
                        if (out_data.frame_event !== want.frame_event ||
                            out_data.target_pan !== want.target_pan ||
                            out_data.target_tilt !== want.target_tilt ||
                            out_data.target_lost !== want.target_lost ||
                            out_data.frame_rate !== want.frame_rate)
                        begin
                            mismatch_count++;
                            if (mismatch_count <= MAX_REPORTS)
                            begin
                                $display("%0t: exp ev=%0d pan=%0d tilt=%0d lost=%0d rate=%0d",
                                         $time, want.frame_event, want.target_pan,
                                         want.target_tilt, want.target_lost,
                                         want.frame_rate);
                                $display("%0t: got ev=%0d pan=%0d tilt=%0d lost=%0d rate=%0d",
                                         $time, out_data.frame_event, out_data.target_pan,
                                         out_data.target_tilt, out_data.target_lost,
                                         out_data.frame_rate);
                            end
                        end
                    end
                end
            end
        end
    end

    task automatic queue_item(logic kind, logic [7:0] value);
        in_item_t it;
        it.kind = kind;
        it.rx_byte = value;
        serial_items.push_back(it);
        items_sent++;
    endtask

    // Queue one complete frame; corrupt the check byte on request
    task automatic queue_frame(logic [7:0] cmd, logic [15:0] pan, logic [15:0] tilt,
                               bit bad_check);
        logic [7:0] body [10];
        logic [7:0] chk;
        body = '{HDR_FIRST, HDR_SECOND, cmd, pan[7:0], pan[15:8], tilt[7:0], tilt[15:8],
                 8'($urandom), 8'($urandom), 8'h00};
        chk = '0;
        for (int i = 0; i < 9; i++)
            chk = chk ^ body[i];
        if (bad_check)
            chk = chk ^ 8'($urandom_range(1, 255));
        body[9] = chk;
        for (int i = 0; i < 10; i++)
            queue_item(KIND_BYTE, body[i]);
    endtask

    // Mostly well-formed frames with random content, mixed with ticks, cut frames and noise
    task automatic queue_random(int count);
        int start;
        int r;
        int cut;
        logic [7:0] cmd;
        start = items_sent;
        while (items_sent - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: cmd = CMD_TRACK;
                    3:       cmd = CMD_MISSING;
                    4:       cmd = CMD_HALT;
                    default: cmd = 8'($urandom);
                endcase
                if ($urandom_range(0, 7) == 0)
                    queue_item(KIND_BYTE, HDR_FIRST);
                queue_frame(cmd, 16'($urandom), 16'($urandom), $urandom_range(0, 9) == 0);
            end
            else if (r < 80)
            begin
                queue_item(KIND_TICK, 8'($urandom));
            end
            else if (r < 90)
            begin
                // Cut a frame short; its tail swallows whatever follows
                queue_item(KIND_BYTE, HDR_FIRST);
                queue_item(KIND_BYTE, HDR_SECOND);
                cut = $urandom_range(0, 6);
                for (int i = 0; i < cut; i++)
                    queue_item(KIND_BYTE, 8'($urandom));
            end
            else
            begin
                queue_item(KIND_BYTE, ($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom));
            end
        end
    endtask

    // Wait until every item is taken and every report has come, then settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_taken != items_sent || target_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_taken = 1'b0;
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: header corner cases, every command, extremes, bad check, ticks
        queue_item(KIND_BYTE, HDR_FIRST);
        queue_item(KIND_BYTE, 8'h33);
        queue_item(KIND_BYTE, HDR_FIRST);
        queue_frame(CMD_TRACK, 16'hFFFF, 16'h0000, 1'b0);
        queue_item(KIND_TICK, 8'hFF);
        queue_item(KIND_TICK, 8'h00);
        queue_frame(CMD_MISSING, 16'h0000, 16'hFFFF, 1'b0);
        queue_frame(CMD_TRACK, 16'h1234, 16'h5678, 1'b1);
        queue_frame(CMD_HALT, 16'hAAAA, 16'h5555, 1'b0);
        queue_frame(CMD_IGNORED, 16'h5555, 16'hAAAA, 1'b0);
        queue_frame(CMD_TRACK, 16'h0000, 16'hFFFF, 1'b0);
        wait_drained();

        // Zero timeout, widest tick; spare indexes must leave both registers alone
        write_reg(CFG_LOST_TIMEOUT, 16'h0000);
        write_reg(CFG_TICK_STEP, 16'h00FF);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0001);
        queue_random(130);
        wait_drained();

        // Longest timeout, smallest tick; hold the receiver off so the block backs up
        write_reg(CFG_LOST_TIMEOUT, 16'hFFFF);
        write_reg(CFG_TICK_STEP, 16'h0001);
        queue_random(110);
        hold_req = 1'b1;
        wait_drained();

        // Tick step masks to zero: ticks still run the window check
        write_reg(CFG_TICK_STEP, 16'hFF00);
        write_reg(CFG_LOST_TIMEOUT, 16'd30);
        queue_random(40);
        wait_drained();

        // Last stretch at full rate with no idling on either side
        idle_on = 1'b0;
        gap_left = 0;
        stall_left = 0;
        write_reg(CFG_LOST_TIMEOUT, 16'd700);
        write_reg(CFG_TICK_STEP, 16'd55);
        queue_random(130);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && target_reports.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
